// ===== rtl/gfd_pkg.sv =====
package gfd_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int PIDX_W        = $clog2(PAYLOAD_BYTES);
  localparam int BIDX_W        = 4;

  // flag byte high nibble carries the payload length
  localparam logic [3:0] FLAG_LEN = 4'(PAYLOAD_BYTES);

  localparam logic [7:0]  RST_FIRST_HEADER  = 8'hFF;
  localparam logic [7:0]  RST_SECOND_HEADER = 8'hAA;
  localparam logic [3:0]  RST_EXPECTED_TYPE = 4'h1;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd400;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HEAD2 = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HEAD2   = 3'd1,
    ST_TYPE    = 3'd2,
    ST_BUTTON  = 3'd3,
    ST_SUM     = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_FIRST_HEADER  = 2'd0,
    REG_SECOND_HEADER = 2'd1,
    REG_EXPECTED_TYPE = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } reg_idx_t;

  typedef enum logic {
    FN_BYTE = 1'b0,
    FN_TICK = 1'b1
  } func_t;

endpackage

// ===== rtl/gamepad_frame_deframer.sv =====
// Controller frame deframer. Each input word is either a received byte
// (in_tuser = 0) or a one millisecond tick (in_tuser = 1). A frame is
// first header, second header, a flag byte (type in the low nibble, 8 in the
// high nibble), eight payload bytes alternating axis and button group, then
// an 8-bit additive checksum of all previous frame bytes. Each finished frame
// or detected fault produces one result word: status in out_tuser, the four
// axes and four button groups in out_tdata (all zero for a fault). Every
// input word is handled by the combinational state update between the input
// handshake and the output register, so one word is accepted per clock as
// long as the output register is empty or being drained in the same cycle.
// The user must write registers through cfg only while idle (not enforced).
module gamepad_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_x, left_y, right_x, right_y, buttons_a, buttons_b, buttons_c, buttons_d
  output logic [63:0] out_tdata,
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gfd_pkg::*;

  logic [7:0]  first_header_r;
  logic [7:0]  second_header_r;
  logic [3:0]  expected_type_r;
  logic [15:0] timeout_ticks_r;

  phase_t              phase_r, phase_nxt;
  logic [BIDX_W-1:0]   byte_index_r, byte_index_nxt;
  logic [7:0]          running_sum_r, running_sum_nxt;
  logic [15:0]         tick_count_r, tick_count_nxt;
  logic [7:0]          store_r [PAYLOAD_BYTES];

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [2:0]  out_status_r;

  logic        accept;
  logic        emit;
  status_t     status;
  logic [16:0] tick_inc;
  logic        timed_out;
  logic        store_wr;
  logic [7:0]  b;
  logic        in_payload;
  logic        last_payload;
  logic        button_bad;
  logic [7:0]  sum_add;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  assign b            = in_tdata;
  assign tick_inc     = {1'b0, tick_count_r} + 17'd1;
  assign timed_out    = tick_inc > {1'b0, timeout_ticks_r};
  assign in_payload   = (byte_index_r != '0) && (byte_index_r <= BIDX_W'(PAYLOAD_BYTES));
  assign last_payload = byte_index_r == BIDX_W'(PAYLOAD_BYTES);
  // the last button group is the byte arriving now
  assign button_bad   = store_r[1][7] | store_r[3][7] | store_r[5][7] | b[7];
  assign sum_add      = running_sum_r + b;

  // phase transitions and result decision
  always_comb begin
    phase_nxt = phase_r;
    emit      = 1'b0;
    status    = ST_OK;
    if (in_tuser == FN_TICK) begin
      if ((phase_r == PH_HEAD2 || phase_r == PH_BODY) && timed_out) begin
        emit   = 1'b1;
        status = ST_TIMEOUT;
      end
    end else begin
      unique case (phase_r)
        PH_HEAD2: begin
          if (b == second_header_r) begin
            phase_nxt = PH_BODY;
          end else if (b != first_header_r) begin
            emit   = 1'b1;
            status = ST_HEAD2;
          end
        end
        PH_BODY: begin
          if (byte_index_r == '0) begin
            if (b[3:0] != expected_type_r || b[7:4] != FLAG_LEN) begin
              emit   = 1'b1;
              status = ST_TYPE;
            end
          end else if (in_payload) begin
            if (last_payload && button_bad) begin
              emit   = 1'b1;
              status = ST_BUTTON;
            end
          end else begin
            emit   = 1'b1;
            status = (b != running_sum_r) ? ST_SUM : ST_OK;
          end
        end
        default: begin
          phase_nxt = (b == first_header_r) ? PH_HEAD2 : PH_HUNT;
        end
      endcase
    end
    if (emit) phase_nxt = PH_HUNT;
  end

  // counters, running sum and payload capture
  always_comb begin
    byte_index_nxt  = byte_index_r;
    running_sum_nxt = running_sum_r;
    tick_count_nxt  = tick_count_r;
    store_wr        = 1'b0;
    if (in_tuser == FN_TICK) begin
      if (phase_r == PH_HEAD2 || phase_r == PH_BODY) tick_count_nxt = tick_inc[15:0];
    end else begin
      unique case (phase_r)
        PH_HEAD2: begin
          tick_count_nxt = '0;
          if (b == second_header_r) begin
            byte_index_nxt  = '0;
            running_sum_nxt = first_header_r + second_header_r;
          end
        end
        PH_BODY: begin
          if (byte_index_r == '0 || in_payload) begin
            running_sum_nxt = sum_add;
            byte_index_nxt  = byte_index_r + BIDX_W'(1);
            store_wr        = in_payload;
          end
        end
        default: begin
          if (b == first_header_r) tick_count_nxt = '0;
        end
      endcase
    end
    if (emit) begin
      byte_index_nxt  = '0;
      running_sum_nxt = '0;
      tick_count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_header_r  <= RST_FIRST_HEADER;
      second_header_r <= RST_SECOND_HEADER;
      expected_type_r <= RST_EXPECTED_TYPE;
      timeout_ticks_r <= RST_TIMEOUT_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FIRST_HEADER:  first_header_r  <= cfg_data[7:0];
        REG_SECOND_HEADER: second_header_r <= cfg_data[7:0];
        REG_EXPECTED_TYPE: expected_type_r <= cfg_data[3:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      byte_index_r  <= '0;
      running_sum_r <= '0;
      tick_count_r  <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      byte_index_r  <= byte_index_nxt;
      running_sum_r <= running_sum_nxt;
      tick_count_r  <= tick_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_wr) begin
      store_r[PIDX_W'(byte_index_r - BIDX_W'(1))] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_status_r <= status;
      if (status == ST_OK) begin
        out_data_r <= {store_r[7], store_r[5], store_r[3], store_r[1],
                       store_r[6], store_r[4], store_r[2], store_r[0]};
      end else begin
        out_data_r <= '0;
      end
    end
  end

endmodule
